@@ hdl/prq_pkg.sv @@
// Shared types and constants of the per-row absmax int8 quantizer.
package prq_pkg;

   // fp32 bit patterns used by the scale path.
   localparam logic [31:0] SCALE_FLOOR_BITS = 32'h2EDB_E6FF;  // 1e-10f
   localparam logic [31:0] RECIP_RESET_BITS = 32'h5015_02F9;  // 1 / 1e-10f
   localparam logic [31:0] FP32_INF_BITS    = 32'h7F80_0000;

   // Biased exponent of 127.0f.
   localparam int          QMAX_EXP  = 133;

   // Largest non-NaN bf16 magnitude (infinity).
   localparam logic [14:0] BF16_INF_MAG = 15'h7F80;

   // Quotient bits produced by the divider: 24 significand bits, guard, spare.
   localparam int QUO_BITS = 27;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // transfer of an input item
      logic scale_fin;  // form, round and store the scale
      logic recip_go;   // start 1 / scale
      logic recip_fin;  // round and store the reciprocal
      logic mul;        // form the element product
      logic rnd;        // round the product to fp32
      logic load;       // write the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ hdl/prq_if.sv @@
// Valid/ready channel interfaces for the quantizer's request and response.
interface prq_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] element_bits;
   logic        row_end;

   modport source (output valid, output operation, output element_bits, output row_end,
                   input ready);
   modport sink   (input valid, input operation, input element_bits, input row_end,
                   output ready);
endinterface

interface prq_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [31:0]        scale_bits;
   logic signed [7:0]  quant_value;
   logic               final_flag;

   modport source (output valid, output kind, output scale_bits, output quant_value,
                   output final_flag, input ready);
   modport sink   (input valid, input kind, input scale_bits, input quant_value,
                   input final_flag, output ready);
endinterface

@@ hdl/prq_div.sv @@
// Restoring divider: one quotient bit per cycle of floor(dividend * 2^26 / divisor).
module prq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [23:0]                   dividend,
   input  logic [23:0]                   divisor,
   output logic                          done,
   output logic [prq_pkg::QUO_BITS-1:0]  quotient,
   output logic                          sticky
);

   localparam logic [4:0] LAST_STEP = 5'(prq_pkg::QUO_BITS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    count_ff, count_in;
   logic [24:0]                   rem_ff, rem_in;
   logic [prq_pkg::QUO_BITS-1:0]  quo_ff, quo_in;
   logic                          ge;
   logic [24:0]                   diff;

   // Trial subtraction of the divisor from the partial remainder.
   always_comb begin
      ge   = rem_ff >= {1'b0, divisor};
      diff = rem_ff - {1'b0, divisor};
   end

   // Next state of the iteration.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
         rem_in   = {1'b0, dividend};
         quo_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[prq_pkg::QUO_BITS-2:0], ge};
         rem_in   = ge ? {diff[23:0], 1'b0} : {rem_ff[23:0], 1'b0};
         count_in = count_ff + 5'd1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Remainder and quotient registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign sticky   = rem_ff != 25'd0;

endmodule

@@ hdl/prq_dp.sv @@
// Datapath: peak tracking, scale and reciprocal, element product, rounding, output register.
module prq_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  prq_pkg::cmd_type     cmd,
   output prq_pkg::status_type  status,
   input  logic                 in_operation,
   input  logic [15:0]          in_element_bits,
   input  logic                 in_row_end,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_kind,
   output logic [31:0]          out_scale_bits,
   output logic signed [7:0]    out_quant_value,
   output logic                 out_final_flag
);

   typedef enum logic [1:0] {
      CLS_NORM = 2'd0,
      CLS_NAN  = 2'd1,
      CLS_INF  = 2'd2,
      CLS_ZERO = 2'd3
   } class_type;

   typedef struct packed {
      logic signed [9:0] e;
      logic [22:0]       m;
   } rnd_type;

   // Round a 27-bit quotient to an fp32 significand, nearest even.
   function automatic rnd_type div_round(input logic [26:0] q, input logic st,
                                         input logic signed [9:0] base);
      rnd_type     r;
      logic [23:0] m;
      logic        g;
      logic        s;
      logic [24:0] sum;
      if (q[26]) begin
         m = q[26:3];
         g = q[2];
         s = q[1] | q[0] | st;
         r.e = base;
      end else begin
         m = q[25:2];
         g = q[1];
         s = q[0] | st;
         r.e = base - 10'sd1;
      end
      sum = {1'b0, m} + {24'b0, g & (s | m[0])};
      if (sum[24]) begin
         r.e = r.e + 10'sd1;
      end
      r.m = sum[24] ? 23'd0 : sum[22:0];
      return r;
   endfunction

   // Captured item and row state.
   logic              op_ff;
   logic              last_ff;
   logic [15:0]       bits_ff;
   logic [14:0]       peak_ff, peak_in;
   logic [14:0]       work_peak_ff;
   logic [31:0]       scale_ff;
   logic [31:0]       recip_ff;
   logic [14:0]       new_peak;

   // Peak / 127 quotient.
   logic [7:0]                    peak_sig;
   logic [6:0]                    peak_rem;
   logic [prq_pkg::QUO_BITS-1:0]  peak_quo;
   logic                          peak_st;

   // Divider wiring.
   logic                          div_start;
   logic [23:0]                   div_a;
   logic [23:0]                   div_b;
   logic                          div_done;
   logic [prq_pkg::QUO_BITS-1:0]  div_q;
   logic                          div_st;
   rnd_type                       scale_r;
   rnd_type                       recip_r;
   logic [31:0]                   scale_cand;
   logic [31:0]                   scale_next;

   // Product path.
   logic [31:0]       prod_ff;
   logic signed [9:0] ubase_ff;
   logic              sign_ff;
   class_type         cls_ff;
   class_type         cls_in;
   logic [23:0]       m24_ff;
   logic signed [9:0] u_ff;
   logic [23:0]       pm;
   logic              pg;
   logic              ps;
   logic signed [9:0] pu;
   logic [24:0]       psum;

   // Integer rounding.
   logic [4:0]        sh;
   logic [47:0]       shifted;
   logic              inc;
   logic [7:0]        mag;
   logic [7:0]        mag_sat;
   logic signed [7:0] qval;

   // Output register.
   logic              out_valid_ff;
   logic              out_kind_ff;
   logic [31:0]       out_scale_ff;
   logic signed [7:0] out_quant_ff;
   logic              out_final_ff;
   logic              out_free;

   // Running peak, ignoring NaN magnitudes.
   always_comb begin
      new_peak = peak_ff;
      if (in_element_bits[14:0] <= prq_pkg::BF16_INF_MAG &&
          in_element_bits[14:0] > peak_ff) begin
         new_peak = in_element_bits[14:0];
      end
      peak_in = peak_ff;
      if (cmd.take && !in_operation) begin
         peak_in = in_row_end ? 15'd0 : new_peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff        <= in_operation;
         last_ff      <= in_row_end;
         bits_ff      <= in_element_bits;
         work_peak_ff <= new_peak;
      end
   end

   // Peak significand over 127: since 1/127 is 2^-7 + 2^-14 + ..., the
   // quotient is the integer part followed by the 7-bit remainder repeated.
   // The result lines up with floor(significand * 2^25 / 127).
   always_comb begin
      peak_sig = {1'b1, work_peak_ff[6:0]};
      if (peak_sig >= 8'd254) begin
         peak_rem = 7'(peak_sig - 8'd254);
         peak_quo = {2'b10, peak_rem, peak_rem, peak_rem, peak_rem[6:3]};
      end else begin
         peak_rem = 7'(peak_sig - 8'd127);
         peak_quo = {2'b01, peak_rem, peak_rem, peak_rem, peak_rem[6:3]};
      end
      peak_st = peak_rem != 7'd0;
   end

   // Divider operands: 1 / scale.
   assign div_start = cmd.recip_go;
   assign div_a     = 24'h80_0000;
   assign div_b     = {1'b1, scale_ff[22:0]};

   prq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q),
      .sticky   (div_st)
   );

   // Scale with floor and infinity, and the rounded reciprocal.
   always_comb begin
      scale_r = div_round(peak_quo, peak_st,
                          $signed({2'b00, work_peak_ff[14:7]}) -
                          10'(prq_pkg::QMAX_EXP - 127));
      recip_r = div_round(div_q, div_st, 10'sd254 - $signed({2'b00, scale_ff[30:23]}));
      scale_cand = {1'b0, scale_r.e[7:0], scale_r.m};
      if (work_peak_ff[14:7] == 8'hFF) begin
         scale_next = prq_pkg::FP32_INF_BITS;
      end else if (work_peak_ff[14:7] == 8'h00 || scale_r.e <= 10'sd0 ||
                   scale_cand < prq_pkg::SCALE_FLOOR_BITS) begin
         scale_next = prq_pkg::SCALE_FLOOR_BITS;
      end else begin
         scale_next = scale_cand;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_fin) begin
         scale_ff <= scale_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= prq_pkg::RECIP_RESET_BITS;
      end else if (cmd.recip_fin) begin
         recip_ff <= (scale_ff == prq_pkg::FP32_INF_BITS) ? 32'd0 :
                     {1'b0, recip_r.e[7:0], recip_r.m};
      end
   end

   // Element class of the product x * recip.
   always_comb begin
      if (bits_ff[14:7] == 8'hFF && bits_ff[6:0] != 7'd0) begin
         cls_in = CLS_NAN;
      end else if (bits_ff[14:7] == 8'hFF) begin
         cls_in = (recip_ff == 32'd0) ? CLS_NAN : CLS_INF;
      end else if (bits_ff[14:7] == 8'h00 || recip_ff == 32'd0) begin
         cls_in = CLS_ZERO;
      end else begin
         cls_in = CLS_NORM;
      end
   end

   // Significand product and exponent sum.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff  <= {1'b1, bits_ff[6:0]} * {1'b1, recip_ff[22:0]};
         ubase_ff <= $signed({2'b00, bits_ff[14:7]}) + $signed({2'b00, recip_ff[30:23]}) -
                     10'sd254;
         sign_ff  <= bits_ff[15] ^ recip_ff[31];
         cls_ff   <= cls_in;
      end
   end

   // Round the product to an fp32 significand.
   always_comb begin
      if (prod_ff[31]) begin
         pm = prod_ff[31:8];
         pg = prod_ff[7];
         ps = |prod_ff[6:0];
         pu = ubase_ff + 10'sd1;
      end else begin
         pm = prod_ff[30:7];
         pg = prod_ff[6];
         ps = |prod_ff[5:0];
         pu = ubase_ff;
      end
      psum = {1'b0, pm} + {24'b0, pg & (ps | pm[0])};
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd) begin
         m24_ff <= psum[24] ? 24'h80_0000 : psum[23:0];
         u_ff   <= psum[24] ? pu + 10'sd1 : pu;
      end
   end

   // Round to integer, ties to even, and clamp to -127..127.
   always_comb begin
      sh      = 5'(10'sd23 - u_ff);
      shifted = {m24_ff, 24'd0} >> sh;
      inc     = shifted[23] & ((|shifted[22:0]) | shifted[24]);
      mag     = {1'b0, shifted[30:24]} + {7'd0, inc};
      mag_sat = (mag >= 8'd127) ? 8'd127 : mag;
      case (cls_ff)
         CLS_NAN:  qval = 8'sd127;
         CLS_INF:  qval = sign_ff ? -8'sd127 : 8'sd127;
         CLS_ZERO: qval = 8'sd0;
         CLS_NORM: begin
            if (u_ff >= 10'sd7) begin
               qval = sign_ff ? -8'sd127 : 8'sd127;
            end else if (u_ff < -10'sd1) begin
               qval = 8'sd0;
            end else begin
               qval = sign_ff ? -$signed(mag_sat) : $signed(mag_sat);
            end
         end
         default:  qval = 8'sd0;
      endcase
   end

   // Output register, freed by a transfer on the response side.
   assign out_free = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_kind_ff  <= op_ff;
         out_scale_ff <= op_ff ? 32'd0 : scale_ff;
         out_quant_ff <= op_ff ? qval : 8'sd0;
         out_final_ff <= op_ff & last_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = out_free;
   assign out_valid       = out_valid_ff;
   assign out_kind        = out_kind_ff;
   assign out_scale_bits  = out_scale_ff;
   assign out_quant_value = out_quant_ff;
   assign out_final_flag  = out_final_ff;

`ifndef SYNTH
   // A load never overwrites a result that has not been transferred.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> out_free) else $error("output register overwritten");

   // A load always presents a result in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> out_valid_ff) else $error("loaded result not presented");

   // The peak never holds a NaN magnitude.
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= prq_pkg::BF16_INF_MAG) else $error("peak holds a NaN magnitude");

   // The stored reciprocal is never negative.
   a_recip_sign: assert property (@(posedge clock) disable iff (reset)
      cmd.recip_fin |=> !recip_ff[31]) else $error("negative reciprocal stored");
`endif

endmodule

@@ hdl/prq_ctrl.sv @@
// Controller state machine sequencing the quantizer datapath.
module prq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_operation,
   input  logic                 in_row_end,
   output logic                 in_ready,
   output prq_pkg::cmd_type     cmd,
   input  prq_pkg::status_type  status
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b000_0001,
      S_SCALE     = 7'b000_0010,
      S_RECIP_GO  = 7'b000_0100,
      S_RECIP_RUN = 7'b000_1000,
      S_MUL       = 7'b001_0000,
      S_RND       = 7'b010_0000,
      S_LOAD      = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;

   assign in_ready = state_ff == S_IDLE;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.take = 1'b1;
               if (in_operation) begin
                  state_in = S_MUL;
               end else if (in_row_end) begin
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            cmd.scale_fin = 1'b1;
            state_in      = S_RECIP_GO;
         end
         S_RECIP_GO: begin
            cmd.recip_go = 1'b1;
            state_in     = S_RECIP_RUN;
         end
         S_RECIP_RUN: begin
            if (status.div_done) begin
               cmd.recip_fin = 1'b1;
               state_in      = S_LOAD;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/per_row_absmax_int8_quantizer.sv @@
// Top level of the per-row absmax int8 quantizer.
//
//   Channel   Direction  Payload
//   req_chan  in         operation, element_bits, row_end
//   rsp_chan  out        kind, scale_bits, quant_value, final_flag
//
// A measure element that is not the last of its row is taken without leaving the idle
// state. The last measure element runs capture, peak / 127 by compare and subtract,
// divider start, a 27-step restoring run for 1 / scale until its done flag, and load.
// A quantize element runs capture, multiply, fp32 round, load; neither takes a new item
// before its load. Reset clears the peak and sets the reciprocal to that of 1e-10.
// A result waits in the output register; the block keeps accepting items
// until it must load a new result while the old one is not yet transferred.
module per_row_absmax_int8_quantizer (
   input  logic       clock,
   input  logic       reset,
   prq_req_if.sink    req_chan,
   prq_rsp_if.source  rsp_chan
);

   prq_pkg::cmd_type    cmd;
   prq_pkg::status_type status;
   logic                in_ready;

   prq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_operation (req_chan.operation),
      .in_row_end   (req_chan.row_end),
      .in_ready     (in_ready),
      .cmd          (cmd),
      .status       (status)
   );

   prq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_operation    (req_chan.operation),
      .in_element_bits (req_chan.element_bits),
      .in_row_end      (req_chan.row_end),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_kind        (rsp_chan.kind),
      .out_scale_bits  (rsp_chan.scale_bits),
      .out_quant_value (rsp_chan.quant_value),
      .out_final_flag  (rsp_chan.final_flag)
   );

   assign req_chan.ready = in_ready;

endmodule
